@@ sv/chm_pkg.sv @@
// ============================================================================
// chm_pkg
// Shared types, sizes and codes of the chained hash map engine.
// ============================================================================
package chm_pkg;

    localparam int MAX_ENTRIES     = 1024;
    localparam int MAX_BUCKET_BITS = 11;
    localparam int BUCKETS         = 1 << MAX_BUCKET_BITS;
    localparam int ENTRY_W         = $clog2(MAX_ENTRIES);
    localparam int LINK_W          = ENTRY_W + 1;
    localparam int COUNT_W         = LINK_W;
    localparam int KEY_W           = 32;
    localparam int VAL_W           = 32;
    localparam int HASH_W          = 32;
    localparam int ACT_W           = 2;
    localparam int STAT_W          = 2;
    localparam int BITS_W          = 4;
    localparam int THR_W           = 8;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 8;
    localparam int CLR_LEN         = (BUCKETS > MAX_ENTRIES) ? BUCKETS : MAX_ENTRIES;
    localparam int CLR_W           = $clog2(CLR_LEN) + 1;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
    localparam int LOAD_W          = ((COUNT_W + 9) > (THR_W + MAX_BUCKET_BITS)) ?
                                     (COUNT_W + 9) : (THR_W + MAX_BUCKET_BITS);

    localparam logic [LINK_W-1:0]  NIL              = LINK_W'(MAX_ENTRIES);
    localparam logic [THR_W-1:0]   THR_RESET        = 8'd192;
    localparam logic [BITS_W-1:0]  START_BITS_RESET = 4'd4;
    localparam logic [HASH_W-1:0]  MIX_C1           = 32'h85ebca6b;
    localparam logic [HASH_W-1:0]  MIX_C2           = 32'hc2b2ae35;

    localparam logic [CFG_IDX_W-1:0] CFG_LOAD_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_BITS     = 2'd1;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUT, ACT_GET, ACT_REMOVE, ACT_CLEAR
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        ST_OK, ST_NOT_FOUND, ST_FULL
    } t_status;

    typedef struct packed {
        t_action             action;
        logic [KEY_W-1:0]    key;
        logic [VAL_W-1:0]    value;
        logic [HASH_W-1:0]   hash;
    } t_item;

    typedef struct packed {
        logic clearing;
    } t_back_stat;

    typedef enum logic [4:0] {
        B_CLR, B_IDLE, B_HEAD, B_HEADW, B_FETCH, B_CMP, B_DECIDE, B_UPD,
        B_ALLOC, B_ALLOC2, B_ALLOC3, B_RM1, B_RM2, B_GRD, B_GRDW, B_GFETCH,
        B_GKEY, B_GH1, B_GH2, B_GWLO, B_GWHI, B_DONE
    } t_bstate;

endpackage

@@ sv/chm_ram.sv @@
// ============================================================================
// chm_ram
// Generic single-write, single-read memory with a registered read.
// ============================================================================
module chm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/chm_hash.sv @@
// ============================================================================
// chm_hash
// Two-stage pipelined murmur-style 32-bit finalizer.
// ============================================================================
module chm_hash import chm_pkg::*; (
    input  logic              i_clk,
    input  logic [KEY_W-1:0]  i_key,
    output logic [HASH_W-1:0] o_hash
);

    logic [HASH_W-1:0] w_x1;
    logic [HASH_W-1:0] w_x2;
    logic [HASH_W-1:0] r_m1;
    logic [HASH_W-1:0] r_m2;

    assign w_x1 = i_key ^ (i_key >> 16);
    assign w_x2 = r_m1 ^ (r_m1 >> 13);

    always_ff @(posedge i_clk) begin
        r_m1 <= w_x1 * MIX_C1;
        r_m2 <= w_x2 * MIX_C2;
    end

    assign o_hash = r_m2 ^ (r_m2 >> 16);

endmodule

@@ sv/chm_front.sv @@
// ============================================================================
// chm_front
// Accepts beats, hashes the key and queues the classified items.
// ============================================================================
module chm_front import chm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [ACT_W-1:0]  i_action,
    input  logic [KEY_W-1:0]  i_key,
    input  logic [VAL_W-1:0]  i_value,
    output logic              o_in_stall,
    input  t_back_stat        i_stat,
    output logic              o_q_valid,
    output t_item             o_q_item,
    input  logic              i_q_pop
);

    logic                w_accept;
    logic [HASH_W-1:0]   w_hash;
    logic                w_push;
    logic                r_v1;
    logic                r_v2;
    t_item               r_p1;
    t_item               r_p2;
    t_item               r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr;
    logic [QPTR_W-1:0]   r_rd;
    logic [QPTR_W:0]     r_cnt;
    logic                w_pop;

    chm_hash u_hash (
        .i_clk  (i_clk),
        .i_key  (i_key),
        .o_hash (w_hash)
    );

    assign o_in_stall = i_stat.clearing ||
        ((4'(r_cnt) + 4'(r_v1) + 4'(r_v2)) >= 4'(QUEUE_DEPTH));
    assign w_accept  = i_in_valid && !o_in_stall;
    assign w_push    = r_v2;
    assign o_q_valid = (r_cnt != '0);
    assign o_q_item  = r_q[r_rd];
    assign w_pop     = i_q_pop && o_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_v1 <= w_accept;
            r_v2 <= r_v1;
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (QPTR_W+1)'(w_push) - (QPTR_W+1)'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1.action <= t_action'(i_action);
        r_p1.key    <= i_key;
        r_p1.value  <= i_value;
        r_p1.hash   <= '0;
        r_p2        <= r_p1;
        if (w_push) begin
            r_q[r_wr] <= '{action: r_p2.action, key: r_p2.key,
                           value: r_p2.value, hash: w_hash};
        end
    end

endmodule

@@ sv/chm_back.sv @@
// ============================================================================
// chm_back
// Executes queued actions on the chained table: chain walk, insert, unlink,
// clearing sweep and in-place rehash on growth.
// ============================================================================
module chm_back import chm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_q_valid,
    input  t_item                 i_q_item,
    output logic                  o_q_pop,
    output t_back_stat            o_stat,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [STAT_W-1:0]     o_status,
    output logic                  o_found,
    output logic [VAL_W-1:0]      o_found_value,
    output logic [COUNT_W-1:0]    o_entry_count,
    output logic [BITS_W-1:0]     o_bucket_bits
);

    t_bstate                    r_state;
    t_bstate                    n_state;
    logic [CLR_W-1:0]           r_ci;
    logic                       r_clr_item;
    t_action                    r_act;
    logic [KEY_W-1:0]           r_key;
    logic [VAL_W-1:0]           r_val;
    logic [HASH_W-1:0]          r_hash;
    logic [LINK_W-1:0]          r_e;
    logic [LINK_W-1:0]          r_prev;
    logic [LINK_W-1:0]          r_elink;
    logic [LINK_W-1:0]          r_nx;
    logic [LINK_W-1:0]          r_hlo;
    logic [LINK_W-1:0]          r_hhi;
    logic [VAL_W-1:0]           r_fval;
    logic                       r_found;
    logic                       r_grown;
    t_status                    r_status;
    logic [LINK_W-1:0]          r_free;
    logic [COUNT_W-1:0]         r_count;
    logic [BITS_W-1:0]          r_bits;
    logic [THR_W-1:0]           r_thr;
    logic [MAX_BUCKET_BITS-1:0] r_gi;
    logic                       r_ov;
    t_status                    r_o_status;
    logic                       r_o_found;
    logic [VAL_W-1:0]           r_o_fval;
    logic [COUNT_W-1:0]         r_o_count;
    logic [BITS_W-1:0]          r_o_bits;

    logic                       h_we;
    logic [MAX_BUCKET_BITS-1:0] h_waddr;
    logic [LINK_W-1:0]          h_wdata;
    logic [MAX_BUCKET_BITS-1:0] h_raddr;
    logic [LINK_W-1:0]          h_rdata;
    logic                       l_we;
    logic [ENTRY_W-1:0]         l_waddr;
    logic [LINK_W-1:0]          l_wdata;
    logic [ENTRY_W-1:0]         l_raddr;
    logic [LINK_W-1:0]          l_rdata;
    logic                       k_we;
    logic [KEY_W-1:0]           k_rdata;
    logic                       v_we;
    logic [VAL_W-1:0]           v_rdata;
    logic [HASH_W-1:0]          w_ghash;

    logic [MAX_BUCKET_BITS-1:0] w_bucket;
    logic [MAX_BUCKET_BITS-1:0] w_old_n;
    logic [ENTRY_W-1:0]         w_e_idx;
    logic [LOAD_W-1:0]          w_lhs;
    logic [LOAD_W-1:0]          w_rhs;
    logic                       w_can_grow;
    logic                       w_clr_last;
    logic                       w_out_take;
    logic                       w_cfg_bits;
    logic [BITS_W-1:0]          w_cfg_sat;

    chm_ram #(.WIDTH(LINK_W), .DEPTH(BUCKETS)) u_heads (
        .i_clk(i_clk), .i_we(h_we), .i_waddr(h_waddr), .i_wdata(h_wdata),
        .i_raddr(h_raddr), .o_rdata(h_rdata)
    );
    chm_ram #(.WIDTH(LINK_W), .DEPTH(MAX_ENTRIES)) u_links (
        .i_clk(i_clk), .i_we(l_we), .i_waddr(l_waddr), .i_wdata(l_wdata),
        .i_raddr(l_raddr), .o_rdata(l_rdata)
    );
    chm_ram #(.WIDTH(KEY_W), .DEPTH(MAX_ENTRIES)) u_keys (
        .i_clk(i_clk), .i_we(k_we), .i_waddr(r_free[ENTRY_W-1:0]), .i_wdata(r_key),
        .i_raddr(w_e_idx), .o_rdata(k_rdata)
    );
    chm_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ENTRIES)) u_values (
        .i_clk(i_clk), .i_we(v_we),
        .i_waddr((r_state == B_UPD) ? w_e_idx : r_free[ENTRY_W-1:0]),
        .i_wdata(r_val), .i_raddr(w_e_idx), .o_rdata(v_rdata)
    );
    chm_hash u_rehash (
        .i_clk(i_clk), .i_key(k_rdata), .o_hash(w_ghash)
    );

    assign w_bucket   = r_hash[MAX_BUCKET_BITS-1:0] &
                        ~({MAX_BUCKET_BITS{1'b1}} << r_bits);
    assign w_old_n    = MAX_BUCKET_BITS'(1) << r_bits;
    assign w_e_idx    = r_e[ENTRY_W-1:0];
    assign w_lhs      = (LOAD_W'(r_count) + LOAD_W'(1)) << 8;
    assign w_rhs      = LOAD_W'(r_thr) << r_bits;
    assign w_can_grow = r_bits < BITS_W'(MAX_BUCKET_BITS);
    assign w_clr_last = (r_ci == CLR_W'(CLR_LEN - 1));
    assign w_out_take = r_ov && !i_out_stall;
    assign w_cfg_bits = i_cfg_we && (i_cfg_index == CFG_START_BITS);
    assign w_cfg_sat  = (i_cfg_data[BITS_W-1:0] > BITS_W'(MAX_BUCKET_BITS)) ?
                        BITS_W'(MAX_BUCKET_BITS) : i_cfg_data[BITS_W-1:0];

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_CLR: begin
                if (w_clr_last) begin
                    n_state = r_clr_item ? B_DONE : B_IDLE;
                end
            end
            B_IDLE: begin
                if (i_q_valid && !r_ov) begin
                    n_state = (i_q_item.action == ACT_CLEAR) ? B_CLR : B_HEAD;
                end
            end
            B_HEAD:  n_state = B_HEADW;
            B_HEADW: n_state = B_FETCH;
            B_FETCH: n_state = (r_e == NIL) ? B_DECIDE : B_CMP;
            B_CMP:   n_state = (k_rdata == r_key) ? B_DECIDE : B_FETCH;
            B_DECIDE: begin
                unique case (r_act)
                    ACT_GET:    n_state = B_DONE;
                    ACT_REMOVE: n_state = (r_e != NIL) ? B_RM1 : B_DONE;
                    default: begin
                        if (!r_grown && (w_lhs > w_rhs)) begin
                            n_state = w_can_grow ? B_GRD : B_DONE;
                        end else if (r_e != NIL) begin
                            n_state = B_UPD;
                        end else if (r_free == NIL) begin
                            n_state = B_DONE;
                        end else begin
                            n_state = B_ALLOC;
                        end
                    end
                endcase
            end
            B_UPD:    n_state = B_DONE;
            B_ALLOC:  n_state = B_ALLOC2;
            B_ALLOC2: n_state = B_ALLOC3;
            B_ALLOC3: n_state = B_DONE;
            B_RM1:    n_state = B_RM2;
            B_RM2:    n_state = B_DONE;
            B_GRD:    n_state = B_GRDW;
            B_GRDW:   n_state = B_GFETCH;
            B_GFETCH: n_state = (r_e == NIL) ? B_GWLO : B_GKEY;
            B_GKEY:   n_state = B_GH1;
            B_GH1:    n_state = B_GH2;
            B_GH2:    n_state = B_GFETCH;
            B_GWLO:   n_state = B_GWHI;
            B_GWHI:   n_state = (r_gi == w_old_n - 1'b1) ? B_HEAD : B_GRD;
            B_DONE:   n_state = B_IDLE;
            default:  n_state = B_IDLE;
        endcase
        if (w_cfg_bits) begin
            n_state = B_CLR;
        end
    end

    // Memory controls.
    always_comb begin
        h_we    = 1'b0;
        h_waddr = w_bucket;
        h_wdata = NIL;
        h_raddr = w_bucket;
        l_we    = 1'b0;
        l_waddr = w_e_idx;
        l_wdata = NIL;
        l_raddr = w_e_idx;
        k_we    = 1'b0;
        v_we    = 1'b0;
        o_q_pop = 1'b0;
        unique case (r_state)
            B_CLR: begin
                h_we    = r_ci < CLR_W'(BUCKETS);
                h_waddr = r_ci[MAX_BUCKET_BITS-1:0];
                l_we    = r_ci < CLR_W'(MAX_ENTRIES);
                l_waddr = r_ci[ENTRY_W-1:0];
                l_wdata = LINK_W'(r_ci) + LINK_W'(1);
            end
            B_IDLE: o_q_pop = i_q_valid && !r_ov;
            B_UPD:  v_we = 1'b1;
            B_ALLOC: l_raddr = r_free[ENTRY_W-1:0];
            B_ALLOC2: begin
                k_we    = 1'b1;
                v_we    = 1'b1;
                l_we    = 1'b1;
                l_waddr = r_free[ENTRY_W-1:0];
            end
            B_ALLOC3, B_RM1: begin
                if (r_prev != NIL) begin
                    l_we    = 1'b1;
                    l_waddr = r_prev[ENTRY_W-1:0];
                    l_wdata = (r_state == B_RM1) ? r_elink : r_e;
                end else begin
                    h_we    = 1'b1;
                    h_wdata = (r_state == B_RM1) ? r_elink : r_e;
                end
            end
            B_RM2: begin
                l_we    = 1'b1;
                l_wdata = r_free;
            end
            B_GRD: h_raddr = r_gi;
            B_GH2: begin
                l_we    = 1'b1;
                l_wdata = w_ghash[r_bits] ? r_hhi : r_hlo;
            end
            B_GWLO: begin
                h_we    = 1'b1;
                h_waddr = r_gi;
                h_wdata = r_hlo;
            end
            B_GWHI: begin
                h_we    = 1'b1;
                h_waddr = r_gi | w_old_n;
                h_wdata = r_hhi;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= B_CLR;
            r_ci       <= '0;
            r_clr_item <= 1'b0;
            r_free     <= '0;
            r_count    <= '0;
            r_bits     <= START_BITS_RESET;
            r_thr      <= THR_RESET;
            r_ov       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_take) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                B_CLR: begin
                    r_ci <= r_ci + 1'b1;
                    if (w_clr_last) begin
                        r_free  <= '0;
                        r_count <= '0;
                    end
                end
                B_RM2: begin
                    r_free <= r_e;
                    if (r_count != '0) begin
                        r_count <= r_count - 1'b1;
                    end
                end
                B_ALLOC2: r_free <= l_rdata;
                B_ALLOC3: r_count <= r_count + 1'b1;
                B_GWHI: begin
                    if (r_gi == w_old_n - 1'b1) begin
                        r_bits <= r_bits + 1'b1;
                    end
                end
                B_DONE: r_ov <= 1'b1;
                default: begin
                end
            endcase
            if (r_state == B_IDLE && i_q_valid && !r_ov) begin
                r_ci       <= '0;
                r_clr_item <= 1'b1;
            end
            if (i_cfg_we && i_cfg_index == CFG_LOAD_THRESHOLD) begin
                r_thr <= (i_cfg_data == '0) ? THR_RESET : i_cfg_data;
            end
            if (w_cfg_bits) begin
                r_bits     <= w_cfg_sat;
                r_ci       <= '0;
                r_clr_item <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_act    <= i_q_item.action;
                r_key    <= i_q_item.key;
                r_val    <= i_q_item.value;
                r_hash   <= i_q_item.hash;
                r_found  <= 1'b0;
                r_grown  <= 1'b0;
                r_status <= ST_OK;
            end
            B_HEAD: r_prev <= NIL;
            B_HEADW: r_e <= h_rdata;
            B_CMP: begin
                if (k_rdata == r_key) begin
                    r_elink <= l_rdata;
                    r_fval  <= v_rdata;
                end else begin
                    r_prev <= r_e;
                    r_e    <= l_rdata;
                end
            end
            B_DECIDE: begin
                if (!r_grown) begin
                    r_found <= (r_e != NIL);
                end
                unique case (r_act)
                    ACT_GET, ACT_REMOVE: begin
                        if (r_e == NIL) begin
                            r_status <= ST_NOT_FOUND;
                        end
                    end
                    default: begin
                        if (!r_grown && (w_lhs > w_rhs)) begin
                            r_gi    <= '0;
                            r_grown <= 1'b1;
                            if (!w_can_grow) begin
                                r_status <= ST_FULL;
                            end
                        end else if (r_e == NIL && r_free == NIL) begin
                            r_status <= ST_FULL;
                        end
                    end
                endcase
            end
            B_ALLOC2: r_e <= r_free;
            B_GRDW: begin
                r_e   <= h_rdata;
                r_hlo <= NIL;
                r_hhi <= NIL;
            end
            B_GKEY: r_nx <= l_rdata;
            B_GH2: begin
                if (w_ghash[r_bits]) begin
                    r_hhi <= r_e;
                end else begin
                    r_hlo <= r_e;
                end
                r_e <= r_nx;
            end
            B_GWHI: r_gi <= r_gi + 1'b1;
            B_DONE: begin
                r_o_status <= r_status;
                r_o_found  <= r_found;
                r_o_fval   <= (r_act == ACT_GET && r_found) ? r_fval : '0;
                r_o_count  <= r_count;
                r_o_bits   <= r_bits;
            end
            default: begin
            end
        endcase
    end

    assign o_stat.clearing = (r_state == B_CLR);
    assign o_out_valid     = r_ov;
    assign o_status        = r_o_status;
    assign o_found         = r_o_found;
    assign o_found_value   = r_o_fval;
    assign o_entry_count   = r_o_count;
    assign o_bucket_bits   = r_o_bits;

endmodule

@@ sv/chained_hash_map_engine_core.sv @@
// ============================================================================
// chained_hash_map_engine_core
// Key-value map over a fixed entry pool with separately chained buckets.
// ============================================================================
// One beat in gives one beat out. The front hashes keys in a two-stage
// pipeline and queues up to four items, so new beats are taken while a
// result waits. The back handles one item at a time: a lookup reads the
// bucket head and then walks the chain, comparing the key of each entry,
// until a match or the end of the chain. A put or remove then writes the
// value, key and link memories as needed. A put that triggers growth first
// rehashes in place, splitting the chain of each old bucket into a low and a
// high bucket, and then repeats its chain walk. After reset, after a clear
// action and after a write of start_bucket_bits, a clearing sweep runs over
// the bucket and link memories, and no beat is taken during it.
module chained_hash_map_engine_core import chm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [ACT_W-1:0]      i_action,
    input  logic [KEY_W-1:0]      i_key,
    input  logic [VAL_W-1:0]      i_value,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [STAT_W-1:0]     o_status,
    output logic                  o_found,
    output logic [VAL_W-1:0]      o_found_value,
    output logic [COUNT_W-1:0]    o_entry_count,
    output logic [BITS_W-1:0]     o_bucket_bits
);

    t_back_stat w_stat;
    logic       w_q_valid;
    t_item      w_q_item;
    logic       w_q_pop;

    chm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_action),
        .i_key      (i_key),
        .i_value    (i_value),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_q_valid  (w_q_valid),
        .o_q_item   (w_q_item),
        .i_q_pop    (w_q_pop)
    );

    chm_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_q_valid     (w_q_valid),
        .i_q_item      (w_q_item),
        .o_q_pop       (w_q_pop),
        .o_stat        (w_stat),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_found       (o_found),
        .o_found_value (o_found_value),
        .o_entry_count (o_entry_count),
        .o_bucket_bits (o_bucket_bits)
    );

endmodule

@@ sv/chm_checker.sv @@
// ============================================================================
// chm_checker
// Port-level checks of the chained hash map engine, bound to the top level.
// ============================================================================
module chm_checker import chm_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_cfg_we,
    input logic [CFG_IDX_W-1:0]  i_cfg_index,
    input logic [CFG_DATA_W-1:0] i_cfg_data,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input logic [ACT_W-1:0]      i_action,
    input logic [KEY_W-1:0]      i_key,
    input logic [VAL_W-1:0]      i_value,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input logic [STAT_W-1:0]     o_status,
    input logic                  o_found,
    input logic [VAL_W-1:0]      o_found_value,
    input logic [COUNT_W-1:0]    o_entry_count,
    input logic [BITS_W-1:0]     o_bucket_bits
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result beat dropped while stalled");

    a_ranges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status != 2'd3) &&
            (o_bucket_bits <= BITS_W'(MAX_BUCKET_BITS)) &&
            (o_entry_count <= COUNT_W'(MAX_ENTRIES)))
        else $error("result field out of range");

    a_missing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_NOT_FOUND) |->
            !o_found && (o_found_value == '0))
        else $error("missing key reported with data");

    a_value_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_found_value != '0) |-> o_found && (o_status == ST_OK))
        else $error("value returned without a hit");

endmodule

bind chained_hash_map_engine_core chm_checker u_chm_checker (.*);
